>>> rtl/gppc_pkg.sv
// ----------------------------------------------------------------------------
// GPIO port pin controller package
// Shared constants, command and status codes, and the controller-to-datapath
// command struct.
// ----------------------------------------------------------------------------
package gppc_pkg;

  // Default geometry of the port array.
  localparam int NUM_PORTS_DEF     = 8;
  localparam int PINS_PER_PORT_DEF = 16;

  // Command codes.
  localparam logic [1:0] CMD_CONFIG = 2'd0;
  localparam logic [1:0] CMD_DRIVE  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_INVALID    = 3'd1;
  localparam logic [2:0] ST_BAD_LEVEL  = 3'd2;
  localparam logic [2:0] ST_NOT_OUTPUT = 3'd3;
  localparam logic [2:0] ST_ALT_MODE   = 3'd4;

  // Pin modes.
  localparam logic [1:0] MODE_INPUT  = 2'd0;
  localparam logic [1:0] MODE_OUTPUT = 2'd1;
  localparam logic [1:0] MODE_ALT    = 2'd2;
  localparam logic [1:0] MODE_ANALOG = 2'd3;

  // Pull and level codes.
  localparam logic [1:0] PULL_MAX    = 2'd2;
  localparam logic [1:0] LEVEL_CLEAR = 2'd0;
  localparam logic [1:0] LEVEL_SET   = 2'd1;
  localparam logic [4:0] ALT_MAX     = 5'd15;

  // Speed limit after reset.
  localparam logic [1:0] MAX_SPEED_RESET = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the input word
    logic exec;  // evaluate the captured word and update the pin state
  } ctl_t;

endpackage

>>> rtl/gppc_ctrl.sv
// ----------------------------------------------------------------------------
// GPIO port pin controller sequencer
// Steps each word through capture, execute and result hand-off.
// ----------------------------------------------------------------------------
module gppc_ctrl
  import gppc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output ctl_t ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign ctl.load  = in_valid && (state == S_IDLE);
  assign ctl.exec  = (state == S_EXEC);

endmodule

>>> rtl/gppc_dp.sv
// ----------------------------------------------------------------------------
// GPIO port pin controller datapath
// Holds the per-port mode and output level state, checks a captured command
// and produces the registered result word.
// ----------------------------------------------------------------------------
module gppc_dp
  import gppc_pkg::*;
#(
  parameter int NUM_PORTS     = NUM_PORTS_DEF,
  parameter int PINS_PER_PORT = PINS_PER_PORT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_data,
  input  logic [1:0]  command,
  input  logic [3:0]  port_number,
  input  logic [15:0] pin_mask,
  input  logic [1:0]  pin_mode,
  input  logic [1:0]  speed_code,
  input  logic [1:0]  pull_code,
  input  logic [4:0]  alt_function,
  input  logic [1:0]  drive_level,
  input  logic [15:0] pad_levels,
  output logic [2:0]  status,
  output logic        pin_level,
  output logic [15:0] port_outputs,
  output logic [7:0]  clock_enables
);

  localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  // Captured input word.
  logic [1:0]  cmd_r;
  logic [3:0]  port_r;
  logic [15:0] mask_r;
  logic [1:0]  mode_r;
  logic [1:0]  speed_r;
  logic [1:0]  pull_r;
  logic [4:0]  alt_r;
  logic [1:0]  level_r;
  logic [15:0] pads_r;

  // Pin state.
  logic [1:0]               mode_q [NUM_PORTS][PINS_PER_PORT];
  logic [PINS_PER_PORT-1:0] lvl_q  [NUM_PORTS];
  logic [NUM_PORTS-1:0]     clk_bits;
  logic [1:0]               max_speed;

  // Execute-stage signals.
  logic [3:0]               port_m1;
  logic [PW-1:0]            pi;
  logic                     port_ok;
  logic                     pin_ok;
  logic [PINS_PER_PORT-1:0] mask_lo;
  logic [1:0]               pin_m;
  logic [PINS_PER_PORT-1:0] lvl_row;
  logic [PINS_PER_PORT-1:0] lvl_row_next;
  logic                     cfg_ok;
  logic                     lvl_set;
  logic                     lvl_clr;
  logic [2:0]               status_next;
  logic                     rd_next;
  logic [NUM_PORTS-1:0]     clk_bits_next;
  logic [15:0]              clk_ext;

  assign port_m1 = port_r - 4'd1;
  assign pi      = port_m1[PW-1:0];
  assign port_ok = (port_r != 4'd0) && ({28'd0, port_r} <= 32'(NUM_PORTS));
  assign pin_ok  = $onehot(mask_r) && ((mask_r >> PINS_PER_PORT) == 16'd0);
  assign mask_lo = mask_r[PINS_PER_PORT-1:0];
  assign lvl_row = port_ok ? lvl_q[pi] : '0;

  // Mode of the selected pin, picked out by the one-hot mask.
  always_comb begin
    pin_m = 2'b00;
    if (port_ok) begin
      for (int i = 0; i < PINS_PER_PORT; i++) begin
        if (mask_lo[i]) pin_m = pin_m | mode_q[pi][i];
      end
    end
  end

  always_comb begin
    status_next = ST_OK;
    rd_next     = 1'b0;
    cfg_ok      = 1'b0;
    lvl_set     = 1'b0;
    lvl_clr     = 1'b0;
    priority if (cmd_r == CMD_NONE || !port_ok || !pin_ok) begin
      status_next = ST_INVALID;
    end else if (cmd_r == CMD_CONFIG) begin
      if (pull_r > PULL_MAX || speed_r > max_speed ||
          (mode_r == MODE_ALT && alt_r > ALT_MAX)) begin
        status_next = ST_INVALID;
      end else begin
        cfg_ok = 1'b1;
      end
    end else if (cmd_r == CMD_DRIVE) begin
      priority if (!pin_m[0]) begin
        status_next = ST_NOT_OUTPUT;
      end else if (level_r == LEVEL_CLEAR) begin
        lvl_clr = 1'b1;
      end else if (level_r == LEVEL_SET) begin
        lvl_set = 1'b1;
      end else begin
        status_next = ST_BAD_LEVEL;
      end
    end else begin
      if (pin_m[1]) begin
        status_next = ST_ALT_MODE;
      end else begin
        rd_next = |(pads_r[PINS_PER_PORT-1:0] & mask_lo);
      end
    end
  end

  always_comb begin
    lvl_row_next = lvl_row;
    if ((cfg_ok && mode_r == MODE_OUTPUT) || lvl_clr) lvl_row_next = lvl_row & ~mask_lo;
    if (lvl_set) lvl_row_next = lvl_row | mask_lo;
  end

  assign clk_bits_next = cfg_ok ? (clk_bits | (NUM_PORTS'(1) << pi)) : clk_bits;
  assign clk_ext       = 16'(clk_bits_next);

  // Input capture and result registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= command;
      port_r  <= port_number;
      mask_r  <= pin_mask;
      mode_r  <= pin_mode;
      speed_r <= speed_code;
      pull_r  <= pull_code;
      alt_r   <= alt_function;
      level_r <= drive_level;
      pads_r  <= pad_levels;
    end
    if (ctl.exec) begin
      status        <= status_next;
      pin_level     <= rd_next;
      port_outputs  <= port_ok ? 16'(lvl_row_next) : 16'd0;
      clock_enables <= clk_ext[7:0];
    end
  end

  // Pin state and the speed limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        lvl_q[p] <= '0;
        for (int i = 0; i < PINS_PER_PORT; i++) begin
          mode_q[p][i] <= MODE_ANALOG;
        end
      end
      clk_bits  <= '0;
      max_speed <= MAX_SPEED_RESET;
    end else begin
      if (cfg_write) max_speed <= cfg_data;
      if (ctl.exec) begin
        clk_bits <= clk_bits_next;
        if (port_ok) lvl_q[pi] <= lvl_row_next;
        if (cfg_ok) begin
          for (int i = 0; i < PINS_PER_PORT; i++) begin
            if (mask_lo[i]) mode_q[pi][i] <= mode_r;
          end
        end
      end
    end
  end

endmodule

>>> rtl/gpio_port_pin_controller.sv
// ----------------------------------------------------------------------------
// GPIO port pin controller
// Each word is captured, evaluated in the execute state and its registered
// result offered in the hand-off state; the three-state sequencer takes no new
// word until the result is handed off; a stalled output holds off the next one.
// Reset: synchronous, active high; all pins analog, output levels and port
// clock enables cleared, speed limit set to its largest code.
// ----------------------------------------------------------------------------
//
// The block serves configure, set/clear and read commands on a bank of GPIO
// ports. Each command names one port (numbered from one) and one pin through a
// one-hot mask. A configure command that passes its field checks enables the
// port clock and records the pin mode; a pin switched to output mode has its
// level cleared. A set/clear command drives the level only for pins whose mode
// has its low bit set, and a read returns the pad level unless the mode has
// its high bit set.
//
// Speed, pull and alternate function settings are only checked for range, and
// the drive type is not used, so only the mode and level state is stored here.
//
// The speed limit register is written through cfg_write and cfg_data; the user
// must write it only while no word is in flight; the block does not enforce it.
module gpio_port_pin_controller
  import gppc_pkg::*;
#(
  parameter int NUM_PORTS     = NUM_PORTS_DEF,
  parameter int PINS_PER_PORT = PINS_PER_PORT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        cfg_write,
  input  logic [1:0]  cfg_data,
  // Input word.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [3:0]  port_number,
  input  logic [15:0] pin_mask,
  input  logic [1:0]  pin_mode,
  input  logic        drive_type,
  input  logic [1:0]  speed_code,
  input  logic [1:0]  pull_code,
  input  logic [4:0]  alt_function,
  input  logic [1:0]  drive_level,
  input  logic [15:0] pad_levels,
  // Result word.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        pin_level,
  output logic [15:0] port_outputs,
  output logic [7:0]  clock_enables
);

  ctl_t ctl;

  // The drive type is accepted for every value, so it never changes a result.
  logic drive_type_unused;
  assign drive_type_unused = drive_type;

  gppc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  gppc_dp #(
    .NUM_PORTS     (NUM_PORTS),
    .PINS_PER_PORT (PINS_PER_PORT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .command       (command),
    .port_number   (port_number),
    .pin_mask      (pin_mask),
    .pin_mode      (pin_mode),
    .speed_code    (speed_code),
    .pull_code     (pull_code),
    .alt_function  (alt_function),
    .drive_level   (drive_level),
    .pad_levels    (pad_levels),
    .status        (status),
    .pin_level     (pin_level),
    .port_outputs  (port_outputs),
    .clock_enables (clock_enables)
  );

endmodule
